[hw/rtl/nkcl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nkcl_pkg
// Shared types and constants of the nearest-k candidate list unit.
// ----------------------------------------------------------------------------
package nkcl_pkg;

    localparam int K_MAX_DEF      = 32;
    localparam int NODE_LIMIT_DEF = 65535;
    localparam int QUEUE_DEPTH    = 2;

    localparam int NODE_W = 16;
    localparam int DIST_W = 32;
    localparam int RANK_W = 5;
    localparam int CNT_W  = 6;

    localparam logic [DIST_W-1:0] NO_EDGE      = '1;
    localparam logic [NODE_W-1:0] EMPTY_NODE   = '0;
    localparam logic [CNT_W-1:0]  CNT_RESET    = 6'd16;

    // Register word indexes on the configuration port.
    localparam logic REG_CAND_COUNT = 1'b0;

    // One classified item as it travels from the front to the back.
    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [DIST_W-1:0] distance;
        logic              ins;
        logic              last;
    } t_item;

    typedef enum logic {
        BK_RUN,
        BK_EMIT
    } t_back_state;

endpackage

[hw/rtl/nearest_k_candidate_list_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_k_candidate_list_unit
// Keeps the k nearest nodes of one distance row and emits them ranked.
// ----------------------------------------------------------------------------
// Usage:
//   One distance row streams in on the s_axis channel, one (node, distance)
//   transfer per cycle while s_axis_tready is high; s_axis_tlast marks the
//   row's final transfer. Each item passes through a front register that
//   classifies it, a two-entry queue, and then the sorted slot list, which
//   inserts one item per cycle while not emitting, with a compare-and-shift
//   in every slot. Self entries, node zero, nodes past NODE_LIMIT and the
//   all-ones "no edge" distance never enter the list. After the last item is
//   inserted, the list shifts out k ranked candidates on the m_axis channel,
//   one transfer per cycle while the receiver is ready, nearest first, and
//   is then cleared. k is the candidate_count register (APB address 0),
//   clamped to 1..K_MAX. While the list is emitting, the queue and front
//   register absorb up to three further items before s_axis_tready drops.
//   The last item passes through the front register and the queue; once it
//   is inserted, the first candidate is loaded into the output register.
//   If the receiver stalls, the output register holds its transfer, the
//   list stops shifting and the input side backs up behind the queue.
//   Reset empties the list and the queue and sets candidate_count to 16.
// ----------------------------------------------------------------------------
module nearest_k_candidate_list_unit #(
    parameter int K_MAX      = nkcl_pkg::K_MAX_DEF,
    parameter int NODE_LIMIT = nkcl_pkg::NODE_LIMIT_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input stream.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,  // node_id[15:0], distance[47:16], row_node[63:48]
    input  wire logic        s_axis_tlast,  // last_in_row
    // Result stream.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata,  // cand_node[15:0], cand_distance[47:16],
                                            // cand_rank[52:48], zero fill[55:53]
    output logic             m_axis_tlast,  // last_of_run
    // Configuration port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [nkcl_pkg::CNT_W-1:0] r_cand_count;

    nkcl_pkg::t_item front_item;
    nkcl_pkg::t_item queue_item;
    logic            front_push;
    logic            queue_full;
    logic            queue_empty;
    logic            back_pop;

    logic [nkcl_pkg::NODE_W-1:0] out_node;
    logic [nkcl_pkg::DIST_W-1:0] out_dist;
    logic [nkcl_pkg::RANK_W-1:0] out_rank;

    // Register file: the write lands in the access phase.
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand_count <= nkcl_pkg::CNT_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == nkcl_pkg::REG_CAND_COUNT) begin
            r_cand_count <= pwdata[nkcl_pkg::CNT_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == nkcl_pkg::REG_CAND_COUNT) begin
            prdata = 32'(r_cand_count);
        end
    end

    nkcl_front #(
        .NODE_LIMIT (NODE_LIMIT)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_node  (s_axis_tdata[15:0]),
        .i_dist  (s_axis_tdata[47:16]),
        .i_row   (s_axis_tdata[63:48]),
        .i_last  (s_axis_tlast),
        .o_push  (front_push),
        .o_item  (front_item),
        .i_full  (queue_full)
    );

    nkcl_queue #(
        .DEPTH (nkcl_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_item  (front_item),
        .o_full  (queue_full),
        .i_pop   (back_pop),
        .o_item  (queue_item),
        .o_empty (queue_empty)
    );

    nkcl_back #(
        .K_MAX (K_MAX)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cand_count (r_cand_count),
        .i_item       (queue_item),
        .i_empty      (queue_empty),
        .o_pop        (back_pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_node       (out_node),
        .o_dist       (out_dist),
        .o_rank       (out_rank),
        .o_last       (m_axis_tlast)
    );

    assign m_axis_tdata = {3'b000, out_rank, out_dist, out_node};

endmodule
`default_nettype wire

[hw/rtl/nkcl_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nkcl_front
// Accepts input transfers, decides whether each item may enter the list and
// holds it in a register until the queue takes it.
// ----------------------------------------------------------------------------
module nkcl_front #(
    parameter int NODE_LIMIT = nkcl_pkg::NODE_LIMIT_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic [nkcl_pkg::NODE_W-1:0] i_node,
    input  wire logic [nkcl_pkg::DIST_W-1:0] i_dist,
    input  wire logic [nkcl_pkg::NODE_W-1:0] i_row,
    input  wire logic                        i_last,
    output logic                             o_push,
    output nkcl_pkg::t_item                  o_item,
    input  wire logic                        i_full
);

    logic            r_valid;
    nkcl_pkg::t_item r_item;
    logic            accept;
    logic            ins;

    // Self entries, node zero and nodes past the limit never enter the list.
    assign ins = (i_node != i_row) && (i_node != '0)
              && (32'(i_node) <= 32'(NODE_LIMIT));

    assign o_push  = r_valid && !i_full;
    assign o_ready = !r_valid || !i_full;
    assign accept  = i_valid && o_ready;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.node     <= i_node;
            r_item.distance <= i_dist;
            r_item.ins      <= ins;
            r_item.last     <= i_last;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/nkcl_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nkcl_queue
// Small first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
module nkcl_queue #(
    parameter int DEPTH = nkcl_pkg::QUEUE_DEPTH
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire nkcl_pkg::t_item i_item,
    output logic                 o_full,
    input  wire logic            i_pop,
    output nkcl_pkg::t_item      o_item,
    output logic                 o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    nkcl_pkg::t_item  r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/nkcl_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nkcl_back
// Sorted slot list with parallel compare-and-shift insertion, and the
// sequencer that shifts the ranked candidates out at the end of a row.
// ----------------------------------------------------------------------------
module nkcl_back #(
    parameter int K_MAX = nkcl_pkg::K_MAX_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic [nkcl_pkg::CNT_W-1:0]   i_cand_count,
    input  wire nkcl_pkg::t_item              i_item,
    input  wire logic                         i_empty,
    output logic                              o_pop,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [nkcl_pkg::NODE_W-1:0]       o_node,
    output logic [nkcl_pkg::DIST_W-1:0]       o_dist,
    output logic [nkcl_pkg::RANK_W-1:0]       o_rank,
    output logic                              o_last
);

    localparam int KW = $clog2(K_MAX + 1);

    nkcl_pkg::t_back_state r_state, n_state;

    logic [nkcl_pkg::DIST_W-1:0] r_dist [K_MAX];
    logic [nkcl_pkg::NODE_W-1:0] r_node [K_MAX];
    logic [nkcl_pkg::DIST_W-1:0] n_dist [K_MAX];
    logic [nkcl_pkg::NODE_W-1:0] n_node [K_MAX];
    logic [nkcl_pkg::DIST_W-1:0] up_dist [K_MAX+1];
    logic [nkcl_pkg::NODE_W-1:0] up_node [K_MAX+1];
    logic [K_MAX:0]              lt_ext;

    logic [KW-1:0] r_k, n_k;
    logic [KW-1:0] r_rank, n_rank;
    logic [KW-1:0] k_sel;
    logic [31:0]   rank_wide;

    logic                        r_out_valid, n_out_valid;
    logic [nkcl_pkg::NODE_W-1:0] r_out_node, n_out_node;
    logic [nkcl_pkg::DIST_W-1:0] r_out_dist, n_out_dist;
    logic [nkcl_pkg::RANK_W-1:0] r_out_rank, n_out_rank;
    logic                        r_out_last, n_out_last;

    logic emit_end;

    // Clamp the requested count to 1..K_MAX.
    always_comb begin
        if (i_cand_count == '0) begin
            k_sel = KW'(1);
        end else if (7'(i_cand_count) > 7'(K_MAX)) begin
            k_sel = KW'(K_MAX);
        end else begin
            k_sel = KW'(i_cand_count);
        end
    end

    // The list is sorted, so the compare vector is a thermometer code; the
    // new item lands where it first rises.
    always_comb begin
        lt_ext[0] = 1'b0;
        for (int t = 0; t < K_MAX; t++) begin
            lt_ext[t+1] = i_item.distance < r_dist[t];
            up_dist[t]  = r_dist[t];
            up_node[t]  = r_node[t];
        end
        up_dist[K_MAX] = nkcl_pkg::NO_EDGE;
        up_node[K_MAX] = nkcl_pkg::EMPTY_NODE;
    end

    assign rank_wide = 32'(r_rank);
    assign o_valid   = r_out_valid;
    assign o_node    = r_out_node;
    assign o_dist    = r_out_dist;
    assign o_rank    = r_out_rank;
    assign o_last    = r_out_last;

    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        n_rank      = r_rank;
        n_out_valid = r_out_valid && !i_ready;
        n_out_node  = r_out_node;
        n_out_dist  = r_out_dist;
        n_out_rank  = r_out_rank;
        n_out_last  = r_out_last;
        o_pop       = 1'b0;
        emit_end    = 1'b0;
        for (int t = 0; t < K_MAX; t++) begin
            n_dist[t] = r_dist[t];
            n_node[t] = r_node[t];
        end
        case (r_state)
            nkcl_pkg::BK_RUN: begin
                o_pop = !i_empty;
                if (!i_empty) begin
                    if (i_item.ins) begin
                        for (int t = 0; t < K_MAX; t++) begin
                            if (lt_ext[t+1] && !lt_ext[t]) begin
                                n_dist[t] = i_item.distance;
                                n_node[t] = i_item.node;
                            end else if (lt_ext[t+1]) begin
                                n_dist[t] = r_dist[t-1 < 0 ? 0 : t-1];
                                n_node[t] = r_node[t-1 < 0 ? 0 : t-1];
                            end
                        end
                    end
                    if (i_item.last) begin
                        n_state = nkcl_pkg::BK_EMIT;
                        n_k     = k_sel;
                        n_rank  = '0;
                    end
                end
            end
            nkcl_pkg::BK_EMIT: begin
                if (!r_out_valid || i_ready) begin
                    emit_end    = (r_rank == r_k - 1'b1);
                    n_out_valid = 1'b1;
                    n_out_dist  = r_dist[0];
                    n_out_node  = (r_dist[0] == nkcl_pkg::NO_EDGE) ?
                                  nkcl_pkg::EMPTY_NODE : r_node[0];
                    n_out_rank  = rank_wide[nkcl_pkg::RANK_W-1:0];
                    n_out_last  = emit_end;
                    n_rank      = r_rank + 1'b1;
                    for (int t = 0; t < K_MAX; t++) begin
                        n_dist[t] = emit_end ? nkcl_pkg::NO_EDGE : up_dist[t+1];
                        n_node[t] = emit_end ? nkcl_pkg::EMPTY_NODE : up_node[t+1];
                    end
                    if (emit_end) begin
                        n_state = nkcl_pkg::BK_RUN;
                    end
                end
            end
            default: begin
                n_state = nkcl_pkg::BK_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= nkcl_pkg::BK_RUN;
            r_k         <= '0;
            r_rank      <= '0;
            r_out_valid <= 1'b0;
            for (int t = 0; t < K_MAX; t++) begin
                r_dist[t] <= nkcl_pkg::NO_EDGE;
                r_node[t] <= nkcl_pkg::EMPTY_NODE;
            end
        end else begin
            r_state     <= n_state;
            r_k         <= n_k;
            r_rank      <= n_rank;
            r_out_valid <= n_out_valid;
            for (int t = 0; t < K_MAX; t++) begin
                r_dist[t] <= n_dist[t];
                r_node[t] <= n_node[t];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_node <= n_out_node;
        r_out_dist <= n_out_dist;
        r_out_rank <= n_out_rank;
        r_out_last <= n_out_last;
    end

endmodule
`default_nettype wire

[tb/sv/nkcl_rank_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nkcl_rank_checker
// Watches the streams and the register port of the candidate list unit,
// keeps its own sorted list, and compares every ranked candidate it emits.
// ----------------------------------------------------------------------------
module nkcl_rank_checker #(
    parameter int K_MAX      = nkcl_pkg::K_MAX_DEF,
    parameter int NODE_LIMIT = nkcl_pkg::NODE_LIMIT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [63:0] i_s_tdata,   // node_id[15:0], distance[47:16], row_node[63:48]
    input  logic        i_s_tlast,   // last_in_row
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [55:0] i_m_tdata,   // cand_node[15:0], cand_distance[47:16],
                                     // cand_rank[52:48], zero fill[55:53]
    input  logic        i_m_tlast,   // last_of_run
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic [31:0] i_prdata,
    input  logic        i_pready,
    output int          o_errors,
    output int          o_pending
);

    localparam logic [2:0] CAND_COUNT_ADDR = {nkcl_pkg::REG_CAND_COUNT, 2'b00};

    typedef struct packed {
        logic [nkcl_pkg::NODE_W-1:0] node;
        logic [nkcl_pkg::DIST_W-1:0] distance;
        logic [nkcl_pkg::RANK_W-1:0] rank;
        logic                        last;
    } t_cand;

    logic [nkcl_pkg::DIST_W-1:0] near_dist [K_MAX];
    logic [nkcl_pkg::NODE_W-1:0] near_node [K_MAX];
    logic [nkcl_pkg::CNT_W-1:0]  cand_count;
    t_cand                       ranked_q [$];
    int                          err_count = 0;
    t_cand                       got;
    logic [nkcl_pkg::NODE_W-1:0] in_node;
    logic [nkcl_pkg::DIST_W-1:0] in_dist;
    logic [nkcl_pkg::NODE_W-1:0] in_row;

    function automatic void clear_nearest();
        for (int t = 0; t < K_MAX; t++) begin
            near_dist[t] = nkcl_pkg::NO_EDGE;
            near_node[t] = nkcl_pkg::EMPTY_NODE;
        end
    endfunction

    // The new entry lands at the first slot holding a strictly larger distance.
    function automatic void insert_nearest(logic [nkcl_pkg::NODE_W-1:0] node,
                                           logic [nkcl_pkg::DIST_W-1:0] distance);
        int pos;
        pos = -1;
        for (int t = 0; t < K_MAX; t++) begin
            if (pos < 0 && distance < near_dist[t]) begin
                pos = t;
            end
        end
        if (pos >= 0) begin
            for (int t = K_MAX - 1; t > pos; t--) begin
                near_dist[t] = near_dist[t-1];
                near_node[t] = near_node[t-1];
            end
            near_dist[pos] = distance;
            near_node[pos] = node;
        end
    endfunction

    function automatic void queue_ranked();
        int    k;
        t_cand c;
        k = int'(cand_count);
        if (k < 1) k = 1;
        if (k > K_MAX) k = K_MAX;
        for (int r = 0; r < k; r++) begin
            c.node     = (near_dist[r] == nkcl_pkg::NO_EDGE) ? nkcl_pkg::EMPTY_NODE
                                                             : near_node[r];
            c.distance = near_dist[r];
            c.rank     = nkcl_pkg::RANK_W'(r);
            c.last     = (r == k - 1);
            ranked_q.push_back(c);
        end
        clear_nearest();
    endfunction

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
            err_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_nearest();
            cand_count = nkcl_pkg::CNT_RESET;
            ranked_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (ranked_q.size() == 0) begin
                    $error("candidate transfer with nothing expected: tdata 0x%0h", i_m_tdata);
                    err_count++;
                end else begin
                    got = ranked_q.pop_front();
                    check_field("cand_node", 32'(got.node), 32'(i_m_tdata[15:0]));
                    check_field("cand_distance", got.distance, i_m_tdata[47:16]);
                    check_field("cand_rank", 32'(got.rank), 32'(i_m_tdata[52:48]));
                    check_field("last_of_run", 32'(got.last), 32'(i_m_tlast));
                end
            end
            if (i_psel && i_penable && i_pready && i_paddr == CAND_COUNT_ADDR) begin
                if (i_pwrite) begin
                    cand_count = i_pwdata[nkcl_pkg::CNT_W-1:0];
                end else begin
                    check_field("candidate_count", 32'(cand_count), i_prdata);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                in_node = i_s_tdata[15:0];
                in_dist = i_s_tdata[47:16];
                in_row  = i_s_tdata[63:48];
                if (in_node != in_row && in_node != '0 && 32'(in_node) <= NODE_LIMIT) begin
                    insert_nearest(in_node, in_dist);
                end
                if (i_s_tlast) begin
                    queue_ranked();
                end
            end
        end
        o_pending <= ranked_q.size();
        o_errors  <= err_count;
    end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the nearest-k candidate list unit.
// Directed rows cover self entries, node zero, the no-edge distance, ties
// and the count extremes; random rows with random gaps and back-pressure
// follow, across several candidate counts and one count change mid-row.
// ----------------------------------------------------------------------------
module tb;

    // Room for an item to pass the front register and the queue and for a row
    // end to empty the list, so this covers any work still in flight.
    localparam int SETTLE_CYCLES  = 3 + nkcl_pkg::K_MAX_DEF + 12;
    // Cycles without any transfer before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 2000;
    // Roughly this many list-entering items go into each random phase.
    localparam int PHASE_ITEMS    = 28;
    localparam int PHASES         = 6;
    localparam logic [2:0] CAND_COUNT_ADDR = {nkcl_pkg::REG_CAND_COUNT, 2'b00};

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic [63:0] s_axis_tdata  = '0;   // node_id[15:0], distance[47:16], row_node[63:48]
    logic        s_axis_tlast  = 1'b0; // last_in_row
    logic        m_axis_tready = 1'b0;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;

    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [55:0] m_axis_tdata;         // cand_node[15:0], cand_distance[47:16],
                                       // cand_rank[52:48], zero fill[55:53]
    logic        m_axis_tlast;         // last_of_run
    logic [31:0] prdata;
    logic        pready;

    int          fail_count;
    int          pending_cands;
    int          quiet_cycles = 0;
    // While set, neither side inserts idle cycles.
    bit          steady_flow  = 1'b0;
    int          entered_items;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    nearest_k_candidate_list_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    nkcl_rank_checker checker_i (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_tready (s_axis_tready),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tlast  (s_axis_tlast),
        .i_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_m_tdata  (m_axis_tdata),
        .i_m_tlast  (m_axis_tlast),
        .i_psel     (psel),
        .i_penable  (penable),
        .i_pwrite   (pwrite),
        .i_paddr    (paddr),
        .i_pwdata   (pwdata),
        .i_prdata   (prdata),
        .i_pready   (pready),
        .o_errors   (fail_count),
        .o_pending  (pending_cands)
    );

    // The receiver stalls in about a third of the cycles unless steady flow is on.
    always @(negedge i_clk) begin
        m_axis_tready <= steady_flow || ($urandom_range(0, 99) >= 34);
    end

    // Any transfer on either stream or the register port resets the watchdog.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Presents one item at a falling edge, after an optional random gap, and
    // holds it until a rising edge sees tready high. It returns at a falling
    // edge so the next item can follow without a bubble.
    task automatic send_item(input logic [15:0] node, input logic [31:0] distance,
                             input logic [15:0] row, input logic last);
        bit taken;
        while (!steady_flow && $urandom_range(0, 99) < 34) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {row, distance, node};
        s_axis_tlast  <= last;
        do begin
            @(posedge i_clk);
            taken = s_axis_tready;
            @(negedge i_clk);
        end while (!taken);
        if (node != row && node != '0 && distance != nkcl_pkg::NO_EDGE) begin
            entered_items++;
        end
    endtask

    // Drops tvalid, waits for every expected candidate, then lets the
    // pipeline settle so that no item is still on its way into the list.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_cands != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // One register write (setup, then access) followed by a read-back. Each
    // transfer ends with an extra falling edge so psel never gets two
    // assignments in one time step.
    task automatic set_cand_count(input logic [31:0] value);
        bit is_write;
        for (int n = 0; n < 2; n++) begin
            is_write = (n == 0);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= is_write;
            paddr   <= CAND_COUNT_ADDR;
            pwdata  <= is_write ? value : '0;
            @(negedge i_clk);
            penable <= 1'b1;
            do @(posedge i_clk); while (!pready);
            @(negedge i_clk);
            psel    <= 1'b0;
            penable <= 1'b0;
            @(negedge i_clk);
        end
    endtask

    // Node ids: many from a small range so that self entries and repeats are
    // common, a few exact self entries and zeros, the rest anywhere.
    function automatic logic [15:0] pick_node(input logic [15:0] row);
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 25) return 16'($urandom_range(1, 40));
        if (sel < 33) return row;
        if (sel < 37) return 16'd0;
        if (sel < 40) return 16'hFFFF;
        return 16'($urandom);
    endfunction

    // Distances: a narrow band makes ties, plus no-edge and both extremes.
    function automatic logic [31:0] pick_distance();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 30) return 32'($urandom_range(0, 20));
        if (sel < 38) return nkcl_pkg::NO_EDGE;
        if (sel < 42) return 32'd0;
        if (sel < 45) return nkcl_pkg::NO_EDGE - 32'd1;
        return $urandom;
    endfunction

    function automatic logic [15:0] pick_row();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) return 16'd0;
        if (sel == 1) return 16'hFFFF;
        if (sel < 6) return 16'($urandom_range(1, 40));
        return 16'($urandom);
    endfunction

    // Streams len items of one row; the final one carries tlast only if the
    // row is to be closed here.
    task automatic send_row(input logic [15:0] row, input int len, input bit close_row);
        for (int i = 0; i < len; i++) begin
            send_item(pick_node(row), pick_distance(), row, close_row && (i == len - 1));
        end
    endtask

    initial begin
        logic [15:0] row;
        int          len;
        logic [31:0] phase_count [PHASES];

        phase_count = '{32'd0, 32'd63, 32'd32, 32'd1, 32'd33, 32'd0};
        phase_count[PHASES-1] = $urandom_range(1, 32);

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed rows at the reset count of 16. The first row mixes a self
        // entry, node zero, a no-edge distance, both distance extremes, the
        // largest node id and a tie, and closes on a self entry, which must
        // still produce the ranked output.
        send_item(16'd5,     32'd10,                      16'd5, 1'b0);
        send_item(16'd0,     32'd3,                       16'd5, 1'b0);
        send_item(16'd7,     nkcl_pkg::NO_EDGE,           16'd5, 1'b0);
        send_item(16'hFFFF,  32'd0,                       16'd5, 1'b0);
        send_item(16'd9,     32'd100,                     16'd5, 1'b0);
        send_item(16'd10,    32'd100,                     16'd5, 1'b0);
        send_item(16'd11,    32'd50,                      16'd5, 1'b0);
        send_item(16'd12,    nkcl_pkg::NO_EDGE - 32'd1,   16'd5, 1'b0);
        send_item(16'd5,     32'd1,                       16'd5, 1'b1);
        // A row of a single skipped item comes out entirely empty.
        send_item(16'd0,     32'd4,                       16'd0, 1'b1);
        send_item(16'hFFFF,  32'd8,                       16'hFFFF, 1'b1);
        wait_idle();

        // Smallest count, with a tie and a no-edge last item.
        set_cand_count(32'd1);
        send_item(16'd3,     32'd7,                       16'd1, 1'b0);
        send_item(16'd4,     32'd7,                       16'd1, 1'b0);
        send_item(16'd2,     nkcl_pkg::NO_EDGE,           16'd1, 1'b1);
        wait_idle();

        // Largest count: most slots stay empty.
        set_cand_count(32'd32);
        for (int i = 0; i < 8; i++) begin
            send_item(16'(100 + i), 32'(1000 - 97 * i), 16'd2, i == 7);
        end
        wait_idle();

        // Random phases. Phase 2 runs without idling on either side; phase 3
        // leaves a row open so that the count changes in the middle of it.
        entered_items = 0;
        row = pick_row();
        for (int p = 0; p < PHASES; p++) begin
            set_cand_count(phase_count[p]);
            steady_flow = (p == 2);
            if (p == 4) begin
                send_row(row, $urandom_range(3, 12), 1'b1);
            end
            while (entered_items < PHASE_ITEMS * (p + 1)) begin
                row = pick_row();
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(33, 45)
                                                  : $urandom_range(1, 16);
                send_row(row, len, 1'b1);
            end
            if (p == 3) begin
                row = pick_row();
                send_row(row, $urandom_range(3, 12), 1'b0);
            end
            wait_idle();
        end
        steady_flow = 1'b0;

        if (fail_count == 0 && pending_cands == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
